>>> sv/gsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared widths, payload types and codes of the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int NUM_SLOTS_DEF = 1024;

    localparam int CMD_W  = 1;
    localparam int HIDX_W = 10;
    localparam int VER_W  = 16;
    localparam int TBL_W  = 8;
    localparam int ST_W   = 2;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [HIDX_W-1:0] t_hidx;
    typedef logic [VER_W-1:0]  t_ver;
    typedef logic [TBL_W-1:0]  t_tbl;
    typedef logic [ST_W-1:0]   t_status;

    // Command codes.
    localparam t_cmd CMD_CREATE  = 1'b0;
    localparam t_cmd CMD_DESTROY = 1'b1;

    // Result status codes.
    localparam t_status ST_CREATED   = 2'd0;
    localparam t_status ST_DESTROYED = 2'd1;
    localparam t_status ST_STALE     = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

endpackage
`default_nettype wire

>>> sv/gsa_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_cmd_if
// Command channel: create or destroy requests with the handle to destroy.
// ----------------------------------------------------------------------------
interface gsa_cmd_if;
    import gsa_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_hidx handle_index;
    t_ver  handle_version;

    modport source (output valid, output command, output handle_index,
                    output handle_version, input ready);
    modport sink   (input valid, input command, input handle_index,
                    input handle_version, output ready);
endinterface
`default_nettype wire

>>> sv/gsa_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_res_if
// Result channel: status of each command and the handle it created.
// ----------------------------------------------------------------------------
interface gsa_res_if;
    import gsa_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_tbl    out_table;
    t_hidx   out_index;
    t_ver    out_version;

    modport source (output valid, output status, output out_table,
                    output out_index, output out_version, input ready);
    modport sink   (input valid, input status, input out_table,
                    input out_index, input out_version, output ready);
endinterface
`default_nettype wire

>>> sv/gsa_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_cfg_if
// Configuration write channel carrying the table number.
// ----------------------------------------------------------------------------
interface gsa_cfg_if;
    import gsa_pkg::*;

    logic valid;
    logic ready;
    t_tbl table_id;

    modport source (output valid, output table_id, input ready);
    modport sink   (input valid, input table_id, output ready);
endinterface
`default_nettype wire

>>> sv/gsa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = gsa_pkg::VER_W,
    parameter int DEPTH = gsa_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> sv/generational_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Hands out and takes back slot handles made of table number, slot index and
// a 16-bit version whose low bit marks the slot as live.
// ----------------------------------------------------------------------------
// Usage
//   i_cmd carries one command per transfer: a create, or a destroy with the
//   handle to give back. Every command yields exactly one transfer on o_res:
//   created (with the new handle), destroyed, stale handle rejected, or no
//   free slot. i_cfg writes the table number stamped into new handles; it is
//   always ready and should only be written while no command is in flight.
// Sequence
//   The accept cycle (S_IDLE) reads the free stack top (create) or the slot
//   version (destroy), S_RD reads the version of the popped slot, and S_FIN
//   writes the version RAM (and the free stack on a destroy) and loads the
//   result register, which offers the result. The next command is taken only
//   once S_FIN has finished, so the block works on one command at a time, set
//   by the two dependent reads of the free stack and version RAMs.
// Reset and stalls
//   Reset empties the free stack, forgets all claimed slots and clears the
//   table number. The RAMs are not cleared: a slot's version is written when
//   it is first claimed, and a destroy of an unclaimed index ignores what it
//   reads. A waiting result does not block the next command; if that one
//   finishes while the sink still stalls, it holds in its last cycle without
//   writing anything until the output register frees up.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
    parameter int NUM_SLOTS = gsa_pkg::NUM_SLOTS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    gsa_cmd_if.sink   i_cmd,
    gsa_cfg_if.sink   i_cfg,
    gsa_res_if.source o_res
);
    import gsa_pkg::*;

    // Slot index width, counter width (must hold NUM_SLOTS itself) and the
    // width used when comparing a handle's index against the claimed count.
    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > HIDX_W) ? CNT_W : HIDX_W;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_SLOTS);
    localparam t_ver             VER_ONE = VER_W'(1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Control state.
    logic [1:0]       r_state,       n_state;
    logic [CNT_W-1:0] r_free_count,  n_free_count;
    logic [CNT_W-1:0] r_claimed,     n_claimed;
    logic             r_out_valid,   n_out_valid;
    t_tbl             r_table_id;

    // Command in flight.
    t_cmd             r_cmd,         n_cmd;
    t_hidx            r_hidx,        n_hidx;
    t_ver             r_hver,        n_hver;
    logic [IDX_W-1:0] r_slot,        n_slot;

    // Result register.
    t_status          r_status,      n_status;
    t_tbl             r_out_table,   n_out_table;
    t_hidx            r_out_index,   n_out_index;
    t_ver             r_out_version, n_out_version;

    // Memory ports.
    logic             ver_we,   ver_re;
    logic [IDX_W-1:0] ver_waddr, ver_raddr;
    t_ver             ver_wdata, ver_rdata;
    logic             stk_we,   stk_re;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    logic [IDX_W-1:0] stk_wdata, stk_rdata;

    logic             cmd_fire;
    logic             commit;
    logic             in_range;
    logic             destroy_ok;
    t_ver             ver_live;

    gsa_ram #(
        .WIDTH (VER_W),
        .DEPTH (NUM_SLOTS)
    ) u_versions (
        .i_clk   (i_clk),
        .i_we    (ver_we),
        .i_waddr (ver_waddr),
        .i_wdata (ver_wdata),
        .i_re    (ver_re),
        .i_raddr (ver_raddr),
        .o_rdata (ver_rdata)
    );

    gsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_SLOTS)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign cmd_fire    = i_cmd.valid && (r_state == S_IDLE);

    // The result register is free when empty or being drained this cycle.
    assign commit = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    // A handle is only checked against the RAM if its slot has been claimed.
    assign in_range   = CMP_W'(r_hidx) < CMP_W'(r_claimed);
    assign destroy_ok = in_range && (ver_rdata == r_hver) && ver_rdata[0]
                        && (r_free_count < CNT_MAX);

    // Version of a created slot: a reused slot keeps its generation, a fresh
    // one starts from zero; either way the low bit marks it live.
    assign ver_live = (r_free_count != '0) ? (ver_rdata | VER_ONE) : VER_ONE;

    always_comb begin
        n_state       = r_state;
        n_free_count  = r_free_count;
        n_claimed     = r_claimed;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_cmd         = r_cmd;
        n_hidx        = r_hidx;
        n_hver        = r_hver;
        n_slot        = r_slot;
        n_status      = r_status;
        n_out_table   = r_out_table;
        n_out_index   = r_out_index;
        n_out_version = r_out_version;

        ver_re    = 1'b0;
        ver_raddr = IDX_W'(i_cmd.handle_index);
        ver_we    = 1'b0;
        ver_waddr = r_slot;
        ver_wdata = ver_live;
        stk_re    = 1'b0;
        stk_raddr = IDX_W'(r_free_count - CNT_ONE);
        stk_we    = 1'b0;
        stk_waddr = IDX_W'(r_free_count);
        stk_wdata = r_slot;

        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_cmd   = i_cmd.command;
                    n_hidx  = i_cmd.handle_index;
                    n_hver  = i_cmd.handle_version;
                    n_state = S_RD;
                    if (i_cmd.command == CMD_DESTROY) begin
                        ver_re = 1'b1;
                    end else begin
                        stk_re = (r_free_count != '0);
                    end
                end
            end
            S_RD: begin
                n_state = S_FIN;
                if (r_cmd == CMD_CREATE) begin
                    if (r_free_count != '0) begin
                        n_slot    = stk_rdata;
                        ver_raddr = stk_rdata;
                        ver_re    = 1'b1;
                    end else begin
                        n_slot = IDX_W'(r_claimed);
                    end
                end else begin
                    n_slot = IDX_W'(r_hidx);
                end
            end
            S_FIN: begin
                if (commit) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_out_table   = '0;
                    n_out_index   = '0;
                    n_out_version = '0;
                    if (r_cmd == CMD_CREATE) begin
                        if ((r_free_count != '0) || (r_claimed < CNT_MAX)) begin
                            ver_we        = 1'b1;
                            n_status      = ST_CREATED;
                            n_out_table   = r_table_id;
                            n_out_index   = HIDX_W'(r_slot);
                            n_out_version = ver_live;
                            if (r_free_count != '0) begin
                                n_free_count = r_free_count - CNT_ONE;
                            end else begin
                                n_claimed = r_claimed + CNT_ONE;
                            end
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else begin
                        if (destroy_ok) begin
                            n_status     = ST_DESTROYED;
                            ver_we       = 1'b1;
                            ver_wdata    = ver_rdata + VER_ONE;
                            stk_we       = 1'b1;
                            n_free_count = r_free_count + CNT_ONE;
                        end else begin
                            n_status = ST_STALE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_claimed    <= '0;
            r_out_valid  <= 1'b0;
            r_table_id   <= '0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_claimed    <= n_claimed;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid) begin
                r_table_id <= i_cfg.table_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_hidx        <= n_hidx;
        r_hver        <= n_hver;
        r_slot        <= n_slot;
        r_status      <= n_status;
        r_out_table   <= n_out_table;
        r_out_index   <= n_out_index;
        r_out_version <= n_out_version;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.out_table   = r_out_table;
    assign o_res.out_index   = r_out_index;
    assign o_res.out_version = r_out_version;

    // Free slots are always a subset of the claimed ones.
    a_free_within_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_claimed)
        else $error("free stack deeper than claimed range");

    // A result only appears when a command finishes.
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result raised outside the final cycle");

    // Every successful create either pops the stack or claims a new slot.
    a_create_moves_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_cmd == CMD_CREATE) && (n_status == ST_CREATED)) |=>
        ((r_free_count == $past(r_free_count) - CNT_ONE) ||
         (r_claimed == $past(r_claimed) + CNT_ONE)))
        else $error("create did not consume a slot");

    // Handed-out handles always carry a live (odd) version.
    a_created_version_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == ST_CREATED)) |-> o_res.out_version[0])
        else $error("created handle with even version");

    // No new command is taken while one is still being worked on.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_fire |=> !i_cmd.ready ##1 !i_cmd.ready)
        else $error("command accepted while another was in flight");
endmodule
`default_nettype wire

>>> sim/slot_handle_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_handle_monitor
// Watches the command, configuration and result channels of the slot
// allocator, keeps its own copy of the slot table and compares every result.
// ----------------------------------------------------------------------------
module slot_handle_monitor #(
    parameter int NUM_SLOTS = gsa_pkg::NUM_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gsa_cmd_if        i_cmd,
    gsa_cfg_if        i_cfg,
    gsa_res_if        i_res,
    output int        o_fail_count,
    output int        o_pending
);
    import gsa_pkg::*;

    typedef struct packed {
        t_status status;
        t_tbl    tbl;
        t_hidx   index;
        t_ver    version;
    } t_alloc_result;

    t_ver          slot_version [NUM_SLOTS];
    t_hidx         free_slots   [NUM_SLOTS];
    int            free_depth    = 0;
    int            claimed_slots = 0;
    t_tbl          table_stamp   = '0;
    t_alloc_result awaited [$];
    int            failures      = 0;

    // Applies one command to the shadow table and returns the result it
    // must produce.
    function automatic t_alloc_result allocate_or_release(t_cmd c, t_hidx idx, t_ver ver);
        t_alloc_result r;
        int            slot;
        t_ver          v;
        r = '0;
        if (c == CMD_CREATE) begin
            if (free_depth > 0) begin
                free_depth--;
                slot = int'(free_slots[free_depth]);
            end else if (claimed_slots < NUM_SLOTS) begin
                slot = claimed_slots;
                claimed_slots++;
                slot_version[slot] = '0;
            end else begin
                r.status = ST_FULL;
                return r;
            end
            v = slot_version[slot] | t_ver'(1);
            slot_version[slot] = v;
            r.status  = ST_CREATED;
            r.tbl     = table_stamp;
            r.index   = t_hidx'(slot);
            r.version = v;
        end else if (int'(idx) < claimed_slots && slot_version[idx] == ver && ver[0]
                     && free_depth < NUM_SLOTS) begin
            free_slots[free_depth] = idx;
            free_depth++;
            slot_version[idx] = ver + 1'b1;
            r.status = ST_DESTROYED;
        end else begin
            r.status = ST_STALE;
        end
        return r;
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            free_depth    = 0;
            claimed_slots = 0;
            table_stamp   = '0;
            awaited.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                table_stamp = i_cfg.table_id;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                awaited.push_back(allocate_or_release(i_cmd.command, i_cmd.handle_index,
                                                      i_cmd.handle_version));
            end
            if (i_res.valid && i_res.ready) begin
                got.status  = i_res.status;
                got.tbl     = i_res.out_table;
                got.index   = i_res.out_index;
                got.version = i_res.out_version;
                if (awaited.size() == 0) begin
                    $error("result transfer with no command outstanding, status %0d",
                           got.status);
                    failures++;
                end else begin
                    want = awaited.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("out_table", want.tbl, got.tbl);
                    check_field("out_index", want.index, got.index);
                    check_field("out_version", want.version, got.version);
                end
            end
        end
        o_pending    <= awaited.size();
        o_fail_count <= failures;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives create and destroy commands into the slot allocator under several
// handshake regimes and lets the monitor check every result.
// ----------------------------------------------------------------------------
module testbench;
    import gsa_pkg::*;

    // Cycles without any transfer before the run is declared hung. The
    // longest legitimate quiet stretch is the deliberate result hold-off.
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int RETIRED_CAP  = 64;
    localparam int FILL_CREATES = NUM_SLOTS_DEF + 4;
    // Destroy/create pairs run on one slot of a full table.
    localparam int REUSE_PAIRS  = 8;

    typedef struct packed {
        t_hidx index;
        t_ver  version;
    } t_slot_handle;

    logic clk = 1'b0;
    logic rst_n;

    gsa_cmd_if cmd_ch ();
    gsa_cfg_if cfg_ch ();
    gsa_res_if res_ch ();

    int fail_count;
    int pending;

    // Handshake regime, set by the stimulus between phases.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit pressure_req  = 1'b0;

    // Handles the block has handed out and not yet been asked to destroy,
    // and a short history of handles already destroyed (for stale attempts).
    t_slot_handle live_handles    [$];
    t_slot_handle retired_handles [$];

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    generational_slot_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    slot_handle_monitor ledger (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ------------------------------------------------------------------------
    // Result side. Ready is random at the current stall rate, except for one
    // long hold-off, counted here, which the stimulus requests once while it
    // keeps offering commands so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (pressure_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // New handles are captured at the edge of their transfer and filed at
    // the following falling edge, so the stimulus, which looks at the list on
    // rising edges, never races with the update.
    logic         created_seen;
    t_slot_handle created_handle;

    always @(posedge clk) begin
        created_seen   <= res_ch.valid && res_ch.ready && res_ch.status == ST_CREATED;
        created_handle <= '{index: res_ch.out_index, version: res_ch.out_version};
    end

    always @(negedge clk) begin
        if (created_seen === 1'b1) begin
            live_handles.push_back(created_handle);
        end
    end

    // A hung block shows up as a long stretch with no transfer on any channel.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("generational_slot_allocator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Command transfer. Valid is left high after a transfer so that a
    // back-to-back command needs no second assignment in the same step; it is
    // only dropped when the sender idles or waits.
    // ------------------------------------------------------------------------
    task automatic issue_command(t_cmd c, t_hidx idx, t_ver ver);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.command        <= c;
        cmd_ch.handle_index   <= idx;
        cmd_ch.handle_version <= ver;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    task automatic issue_create();
        issue_command(CMD_CREATE, t_hidx'($urandom_range(1023)), t_ver'($urandom_range(65535)));
    endtask

    // Waits until more than 'have' handles are on file, then takes the newest.
    task automatic take_handle(int have, output t_slot_handle h);
        if (live_handles.size() <= have) begin
            cmd_ch.valid <= 1'b0;
            while (live_handles.size() <= have) @(posedge clk);
        end
        h = live_handles.pop_back();
    endtask

    task automatic retire(t_slot_handle h);
        retired_handles.push_back(h);
        if (retired_handles.size() > RETIRED_CAP) begin
            void'(retired_handles.pop_front());
        end
    endtask

    // Stops sending and waits until every outstanding result has come back
    // and the last new handle is on file.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Table number writes happen only with nothing in flight.
    task automatic write_table_id(t_tbl value);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.table_id <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic start_phase(int idle_pct, int stall, t_tbl stamp);
        drain_results();
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        write_table_id(stamp);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic. Mostly well-formed use: creates, and destroys of
    // handles actually held. The rest are stale attempts: a handle already
    // destroyed, the dead even version of such a handle, a live handle with
    // one version bit flipped, and entirely random handles.
    // ------------------------------------------------------------------------
    task automatic churn_handles(int count);
        t_slot_handle h;
        int           roll;
        int           pick;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (live_handles.size() == 0
                    || roll < (live_handles.size() < 8 ? 70 : 45)) begin
                issue_create();
            end else begin
                roll = $urandom_range(99);
                if (roll < 60 || retired_handles.size() == 0) begin
                    pick = $urandom_range(live_handles.size() - 1);
                    h    = live_handles[pick];
                    live_handles.delete(pick);
                    retire(h);
                    issue_command(CMD_DESTROY, h.index, h.version);
                end else if (roll < 70) begin
                    h = retired_handles[$urandom_range(retired_handles.size() - 1)];
                    issue_command(CMD_DESTROY, h.index, h.version);
                end else if (roll < 78) begin
                    h = retired_handles[$urandom_range(retired_handles.size() - 1)];
                    issue_command(CMD_DESTROY, h.index, h.version + 1'b1);
                end else if (roll < 88) begin
                    h = live_handles[$urandom_range(live_handles.size() - 1)];
                    issue_command(CMD_DESTROY, h.index,
                                  h.version ^ (t_ver'(1) << $urandom_range(15)));
                end else begin
                    issue_command(CMD_DESTROY, t_hidx'($urandom_range(1023)),
                                  t_ver'($urandom_range(65535)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_slot_handle h;
        t_slot_handle h2;
        t_slot_handle h3;
        int           have;

        rst_n                 <= 1'b0;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.command        <= CMD_CREATE;
        cmd_ch.handle_index   <= '0;
        cmd_ch.handle_version <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.table_id       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_table_id(8'hFF);

        // Directed part. On an empty table every destroy is refused because
        // no index has been claimed yet, whatever the version.
        issue_command(CMD_DESTROY, t_hidx'(0), t_ver'(0));
        issue_command(CMD_DESTROY, t_hidx'(1023), t_ver'(16'hFFFF));
        // The handle fields of a create are ignored: try both extremes.
        issue_command(CMD_CREATE, t_hidx'(1023), t_ver'(16'hFFFF));
        issue_command(CMD_CREATE, t_hidx'(0), t_ver'(0));
        take_handle(1, h);
        issue_command(CMD_DESTROY, h.index, h.version);
        retire(h);
        // Same handle again: the stored version has moved on, so it is stale.
        issue_command(CMD_DESTROY, h.index, h.version);
        // Matching the stored version of a dead slot is still refused.
        issue_command(CMD_DESTROY, h.index, h.version + 1'b1);
        // Index just past the claimed range.
        issue_command(CMD_DESTROY, t_hidx'(2), t_ver'(1));
        // Reuses the slot just freed, with the next odd version.
        issue_create();
        take_handle(1, h2);
        issue_command(CMD_DESTROY, h2.index, h2.version ^ t_ver'(16'h8000));
        issue_command(CMD_DESTROY, h2.index, h2.version);
        retire(h2);
        take_handle(0, h3);
        issue_command(CMD_DESTROY, h3.index, h3.version);
        retire(h3);
        // Two creates now come off the free list last in, first out.
        issue_create();
        issue_create();

        // Random part under each handshake regime. In the first one the
        // result side is held off for a long stretch part way through.
        start_phase(0, 0, 8'h00);
        churn_handles(40);
        pressure_req = 1'b1;
        churn_handles(200);
        start_phase(77, 0, t_tbl'($urandom_range(255)));
        churn_handles(240);
        start_phase(0, 77, t_tbl'($urandom_range(255)));
        churn_handles(240);
        start_phase(25, 25, t_tbl'($urandom_range(255)));
        churn_handles(240);

        // Fill every slot; the last few creates must find the table full.
        start_phase(0, 0, t_tbl'($urandom_range(255)));
        for (int i = 0; i < FILL_CREATES; i++) begin
            issue_create();
        end

        // Cycle a single slot through destroy and create a few times. The
        // free list is empty here, so each create gets back exactly the slot
        // just destroyed, with its version advanced by two.
        start_phase(0, 0, t_tbl'($urandom_range(255)));
        h    = live_handles.pop_back();
        have = live_handles.size();
        repeat (REUSE_PAIRS) begin
            issue_command(CMD_DESTROY, h.index, h.version);
            issue_create();
            take_handle(have, h);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("generational_slot_allocator verification clean");
        end else begin
            $display("generational_slot_allocator verification failed");
        end
        $finish;
    end

endmodule
